/* hdl/ucmd_pkg.sv */
// Shared types, constants and character helpers of the UART motor and servo command decoder.
package ucmd_pkg;

	// Line collection
	localparam int LINE_CAPACITY = 63;
	localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
	localparam int HEAD_DEPTH    = 4;

	// Register reset values
	localparam logic [15:0] MOTOR_FULL_RST = 16'd4799;
	localparam logic [15:0] SERVO_LOW_RST  = 16'd1655;
	localparam logic [15:0] SERVO_HIGH_RST = 16'd8275;

	// Register indexes
	localparam logic [1:0] CFG_MOTOR_FULL = 2'd0;
	localparam logic [1:0] CFG_SERVO_LOW  = 2'd1;
	localparam logic [1:0] CFG_SERVO_HIGH = 2'd2;

	// Characters
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_M   = 8'h4D;
	localparam logic [7:0] CHAR_S   = 8'h53;
	localparam logic [7:0] CHAR_ONE = 8'h31;
	localparam logic [7:0] CHAR_TWO = 8'h32;

	// Duty limit
	localparam logic signed [7:0] DUTY_MAX = 8'sd100;
	localparam logic signed [7:0] DUTY_MIN = -8'sd100;

	// Arithmetic widths. A product is at most 100 * 65535, which fits in 23 bits
	// of magnitude. Division by 100 is done as a shift by two followed by an
	// exact reciprocal multiply for division by 25 on a 21-bit value.
	localparam int PROD_W    = 25;
	localparam int MAG_W     = 23;
	localparam int DIV_IN_W  = MAG_W - 2;
	localparam int RECIP_W   = 22;
	localparam int DIV_SHIFT = 26;
	localparam int RPROD_W   = DIV_IN_W + RECIP_W;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 22'd2684355;

	typedef enum logic [2:0] {
		ST_MOTOR_SET = 3'd0,
		ST_SERVO_SET = 3'd1,
		ST_BAD_MOTOR = 3'd2,
		ST_BAD_SERVO = 3'd3,
		ST_INVALID   = 3'd4
	} status_t;

	typedef struct packed {
		status_t           status;
		logic [1:0]        unit;
		logic signed [7:0] duty;
	} cmd_t;

	// Bit 4 flags a valid hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		logic [4:0] r;
		begin
			d = 8'h00;
			r = 5'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				d = c - 8'h30;
				r = {1'b1, d[3:0]};
			end else if (c >= 8'h41 && c <= 8'h46) begin
				d = c - 8'h37;
				r = {1'b1, d[3:0]};
			end else if (c >= 8'h61 && c <= 8'h66) begin
				d = c - 8'h57;
				r = {1'b1, d[3:0]};
			end
			return r;
		end
	endfunction

	// Space, tab, vertical tab and form feed.
	function automatic logic is_blank(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
	endfunction

	// Two characters of hex, read as a signed byte and clamped to the duty range.
	function automatic logic signed [7:0] parse_duty(input logic [7:0] a, input logic [7:0] b);
		logic [4:0]        ha;
		logic [4:0]        hb;
		logic [7:0]        v;
		logic signed [7:0] s;
		begin
			ha = hex_digit(a);
			hb = hex_digit(b);
			v  = 8'h00;
			if (is_blank(a)) begin
				if (hb[4]) v = {4'h0, hb[3:0]};
			end else if (ha[4]) begin
				if (hb[4]) v = {ha[3:0], hb[3:0]};
				else       v = {4'h0, ha[3:0]};
			end
			s = $signed(v);
			if (s > DUTY_MAX)      s = DUTY_MAX;
			else if (s < DUTY_MIN) s = DUTY_MIN;
			return s;
		end
	endfunction

endpackage

/* hdl/ucmd_line.sv */
// Line collector and command decoder, ending in the first pipeline register.
module ucmd_line (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          rx_byte,
	output logic                is_term,
	output ucmd_pkg::cmd_t      cmd_s1
);

	logic [ucmd_pkg::LEN_W-1:0] len_q;
	logic [7:0]                 head_q [ucmd_pkg::HEAD_DEPTH];
	logic                       load;
	logic                       store;
	logic                       is_motor;
	ucmd_pkg::cmd_t             cmd_d;

	assign is_term = rx_byte == ucmd_pkg::CHAR_CR || rx_byte == ucmd_pkg::CHAR_LF;
	assign load    = accept && is_term;
	assign store   = accept && !is_term &&
			len_q < ucmd_pkg::LEN_W'(ucmd_pkg::LINE_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (load) begin
			len_q <= '0;
		end else if (store) begin
			len_q <= len_q + ucmd_pkg::LEN_W'(1);
		end
	end

	// Only the first four characters of a line are kept.
	always_ff @(posedge clk) begin
		if (store && len_q < ucmd_pkg::LEN_W'(ucmd_pkg::HEAD_DEPTH)) begin
			head_q[len_q[1:0]] <= rx_byte;
		end
	end

	always_comb begin
		cmd_d.status = ucmd_pkg::ST_INVALID;
		cmd_d.unit   = 2'd0;
		cmd_d.duty   = 8'sd0;
		is_motor     = head_q[0] == ucmd_pkg::CHAR_M;
		if (len_q >= ucmd_pkg::LEN_W'(ucmd_pkg::HEAD_DEPTH) &&
				(is_motor || head_q[0] == ucmd_pkg::CHAR_S)) begin
			if (head_q[1] != ucmd_pkg::CHAR_ONE && head_q[1] != ucmd_pkg::CHAR_TWO) begin
				cmd_d.status = is_motor ? ucmd_pkg::ST_BAD_MOTOR : ucmd_pkg::ST_BAD_SERVO;
			end else begin
				cmd_d.status = is_motor ? ucmd_pkg::ST_MOTOR_SET : ucmd_pkg::ST_SERVO_SET;
				cmd_d.unit   = (head_q[1] == ucmd_pkg::CHAR_ONE) ? 2'd1 : 2'd2;
				cmd_d.duty   = ucmd_pkg::parse_duty(head_q[2], head_q[3]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

/* hdl/ucmd_mul.sv */
// Scaling multiplier stage: duty times motor full scale or servo span.
module ucmd_mul (
	input  logic                                clk,
	input  logic                                load,
	input  ucmd_pkg::cmd_t                      cmd_s1,
	input  logic [15:0]                         motor_full,
	input  logic [15:0]                         servo_low,
	input  logic [15:0]                         servo_high,
	output ucmd_pkg::cmd_t                      cmd_s2,
	output logic signed [ucmd_pkg::PROD_W-1:0]  prod_s2
);

	logic               is_motor;
	logic signed [7:0]  op_a;
	logic signed [16:0] op_b;

	// The motor uses the duty magnitude, the servo the signed duty and span.
	always_comb begin
		is_motor = cmd_s1.status == ucmd_pkg::ST_MOTOR_SET;
		if (is_motor) begin
			op_a = cmd_s1.duty[7] ? -cmd_s1.duty : cmd_s1.duty;
			op_b = $signed({1'b0, motor_full});
		end else begin
			op_a = cmd_s1.duty;
			op_b = $signed({1'b0, servo_high}) - $signed({1'b0, servo_low});
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s2  <= cmd_s1;
			prod_s2 <= op_a * op_b;
		end
	end

endmodule

/* hdl/ucmd_div.sv */
// Division by 100, truncated toward zero, through a reciprocal multiply.
module ucmd_div (
	input  logic                                clk,
	input  logic                                load,
	input  ucmd_pkg::cmd_t                      cmd_s2,
	input  logic signed [ucmd_pkg::PROD_W-1:0]  prod_s2,
	output ucmd_pkg::cmd_t                      cmd_s3,
	output logic [15:0]                         quot_s3,
	output logic                                neg_s3
);

	logic signed [ucmd_pkg::PROD_W-1:0] abs_val;
	logic [ucmd_pkg::DIV_IN_W-1:0]      div_in;
	logic [ucmd_pkg::RPROD_W-1:0]       recip_prod;

	// Magnitude divided by 4, then by 25 with an exact reciprocal.
	always_comb begin
		abs_val    = prod_s2[ucmd_pkg::PROD_W-1] ? -prod_s2 : prod_s2;
		div_in     = abs_val[ucmd_pkg::MAG_W-1:2];
		recip_prod = ucmd_pkg::RPROD_W'(div_in) * ucmd_pkg::RPROD_W'(ucmd_pkg::DIV_RECIP);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s3  <= cmd_s2;
			quot_s3 <= recip_prod[ucmd_pkg::DIV_SHIFT +: 16];
			neg_s3  <= prod_s2[ucmd_pkg::PROD_W-1];
		end
	end

endmodule

/* hdl/uart_motor_servo_command_decoder.sv */
// Top level of the UART motor and servo command decoder.
//
//  Channel   Signals                                  Direction  Transfer when
//  --------  ---------------------------------------  ---------  -----------------------
//  input     in_valid, in_stall, rx_byte               in         in_valid && !in_stall
//  result    out_valid, out_stall, status .. pulses    out        out_valid && !out_stall
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid && cfg_ready
//
// One byte can be taken in every cycle while in_stall is low. Ordinary
// characters only update the line state; a CR or LF launches one result
// down a four-register pipeline (decode, scaling multiply, divide-by-100
// multiply, output register). Reset restores the three registers to their
// defaults, empties the line and the pipeline. A stall on the result side
// holds the output register while the stages behind it keep filling;
// in_stall rises only once every stage is occupied. Configuration writes
// are always taken at once.
module uart_motor_servo_command_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [1:0]        unit,
	output logic signed [7:0] duty,
	output logic [15:0]       forward_pulse,
	output logic [15:0]       reverse_pulse,
	output logic [15:0]       servo_pulse,
	output logic              servo_pulse_negative,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	// Configuration registers.
	logic [15:0] motor_full_q;
	logic [15:0] servo_low_q;
	logic [15:0] servo_high_q;

	// Pipeline occupancy and flow control.
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic out_valid_q;
	logic rdy_out;
	logic rdy_s3;
	logic rdy_s2;
	logic rdy_s1;
	logic accept;
	logic is_term;

	// Stage payloads.
	ucmd_pkg::cmd_t                     cmd_s1;
	ucmd_pkg::cmd_t                     cmd_s2;
	ucmd_pkg::cmd_t                     cmd_s3;
	logic signed [ucmd_pkg::PROD_W-1:0] prod_s2;
	logic [15:0]                        quot_s3;
	logic                               neg_s3;

	// Final shaping of the result.
	logic signed [16:0] signed_quot;
	logic signed [17:0] servo_val;
	logic               servo_neg;
	logic [15:0]        servo_sat;
	logic               duty_nonneg;
	logic [15:0]        fwd_d;
	logic [15:0]        rev_d;
	logic [15:0]        spulse_d;
	logic               sneg_d;

	// Output register.
	ucmd_pkg::status_t  status_q;
	logic [1:0]         unit_q;
	logic signed [7:0]  duty_q;
	logic [15:0]        fwd_q;
	logic [15:0]        rev_q;
	logic [15:0]        spulse_q;
	logic               sneg_q;

	// Register writes are taken in any cycle; the index beyond the last
	// register is simply ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_full_q <= ucmd_pkg::MOTOR_FULL_RST;
			servo_low_q  <= ucmd_pkg::SERVO_LOW_RST;
			servo_high_q <= ucmd_pkg::SERVO_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ucmd_pkg::CFG_MOTOR_FULL: motor_full_q <= cfg_data;
				ucmd_pkg::CFG_SERVO_LOW:  servo_low_q  <= cfg_data;
				ucmd_pkg::CFG_SERVO_HIGH: servo_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Each stage moves on when the stage ahead is empty or moving too.
	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy_s3   = !v_s3 || rdy_out;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign accept   = in_valid && rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1        <= (accept && is_term) || (v_s1 && !rdy_s2);
			v_s2        <= (v_s1 && rdy_s2) || (v_s2 && !rdy_s3);
			v_s3        <= (v_s2 && rdy_s3) || (v_s3 && !rdy_out);
			out_valid_q <= (v_s3 && rdy_out) || (out_valid_q && out_stall);
		end
	end

	ucmd_line u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.is_term (is_term),
		.cmd_s1  (cmd_s1)
	);

	ucmd_mul u_mul (
		.clk        (clk),
		.load       (v_s1 && rdy_s2),
		.cmd_s1     (cmd_s1),
		.motor_full (motor_full_q),
		.servo_low  (servo_low_q),
		.servo_high (servo_high_q),
		.cmd_s2     (cmd_s2),
		.prod_s2    (prod_s2)
	);

	ucmd_div u_div (
		.clk     (clk),
		.load    (v_s2 && rdy_s3),
		.cmd_s2  (cmd_s2),
		.prod_s2 (prod_s2),
		.cmd_s3  (cmd_s3),
		.quot_s3 (quot_s3),
		.neg_s3  (neg_s3)
	);

	// The motor pulse goes to one side by the sign of the duty. The servo
	// pulse adds the low end back in; a result below zero raises the flag
	// and one above the 16-bit range saturates. Only servo unit 1 drives a
	// pulse, and only for a non-negative duty.
	always_comb begin
		signed_quot = neg_s3 ? -$signed({1'b0, quot_s3}) : $signed({1'b0, quot_s3});
		servo_val   = $signed({signed_quot[16], signed_quot}) + $signed({2'b00, servo_low_q});
		servo_neg   = servo_val[17];
		servo_sat   = servo_val[16] ? 16'hFFFF : servo_val[15:0];
		duty_nonneg = !cmd_s3.duty[7];
		fwd_d       = 16'd0;
		rev_d       = 16'd0;
		spulse_d    = 16'd0;
		sneg_d      = 1'b0;
		unique case (cmd_s3.status)
			ucmd_pkg::ST_MOTOR_SET: begin
				if (duty_nonneg) fwd_d = quot_s3;
				else             rev_d = quot_s3;
			end
			ucmd_pkg::ST_SERVO_SET: begin
				sneg_d = servo_neg;
				if (cmd_s3.unit == 2'd1 && duty_nonneg && !servo_neg) spulse_d = servo_sat;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_out) begin
			status_q <= cmd_s3.status;
			unit_q   <= cmd_s3.unit;
			duty_q   <= cmd_s3.duty;
			fwd_q    <= fwd_d;
			rev_q    <= rev_d;
			spulse_q <= spulse_d;
			sneg_q   <= sneg_d;
		end
	end

	assign out_valid            = out_valid_q;
	assign status               = status_q;
	assign unit                 = unit_q;
	assign duty                 = duty_q;
	assign forward_pulse        = fwd_q;
	assign reverse_pulse        = rev_q;
	assign servo_pulse          = spulse_q;
	assign servo_pulse_negative = sneg_q;

`ifndef ASSERT_OFF
	// A terminator transfer always starts a result in the decode stage.
	a_term_launches: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && is_term) |=> v_s1)
		else $error("terminator transfer did not load the decode stage");

	// A motor result never drives both sides of the bridge.
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (forward_pulse == 16'd0 || reverse_pulse == 16'd0))
		else $error("forward and reverse pulses both nonzero");

	// Error results carry no unit, duty or pulse.
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ucmd_pkg::ST_BAD_MOTOR || status == ucmd_pkg::ST_BAD_SERVO
			|| status == ucmd_pkg::ST_INVALID)) |->
		(unit == 2'd0 && duty == 8'sd0 && forward_pulse == 16'd0 && reverse_pulse == 16'd0
			&& servo_pulse == 16'd0 && !servo_pulse_negative))
		else $error("error result carries payload");

	// A motor result leaves the servo outputs at rest.
	a_motor_no_servo: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ucmd_pkg::ST_MOTOR_SET) |->
		(servo_pulse == 16'd0 && !servo_pulse_negative))
		else $error("motor result drives servo outputs");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for the UART motor and servo command decoder, with a line-level predictor.
`timescale 1ns / 100ps

module tb;

	// Run control. The watchdog limit covers the long receiver hold, the longest
	// sender gap and the pipeline depth many times over.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 150;
	localparam int PHASE_BYTES    = 45;

	// A register index that maps to no register; a write to it must change nothing.
	localparam logic [1:0] CFG_SPARE = 2'd3;

	// Characters the decoder treats specially, beyond those in the package.
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_VTAB    = 8'h0B;
	localparam logic [7:0] CH_FFEED   = 8'h0C;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;

	// One decoded command as it should leave the block.
	typedef struct packed {
		ucmd_pkg::status_t status;
		logic [1:0]        unit;
		logic signed [7:0] duty;
		logic [15:0]       fwd;
		logic [15:0]       rev;
		logic [15:0]       servo;
		logic              neg;
	} cmd_reply_t;

	// Block inputs, all known from time zero.
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  rx_byte   = 8'h00;
	logic        out_stall = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = ucmd_pkg::CFG_MOTOR_FULL;
	logic [15:0] cfg_data  = 16'h0000;

	// Block outputs.
	logic              in_stall;
	logic              out_valid;
	logic [2:0]        status;
	logic [1:0]        unit;
	logic signed [7:0] duty;
	logic [15:0]       forward_pulse;
	logic [15:0]       reverse_pulse;
	logic [15:0]       servo_pulse;
	logic              servo_pulse_negative;
	logic              cfg_ready;

	// Predictor state: the head of the current line, its length and a copy of
	// the three registers. The registers change only while the block is idle.
	logic [7:0]  line_head [ucmd_pkg::HEAD_DEPTH] = '{default: 8'h00};
	int          line_len   = 0;
	logic [15:0] motor_full = ucmd_pkg::MOTOR_FULL_RST;
	logic [15:0] servo_low  = ucmd_pkg::SERVO_LOW_RST;
	logic [15:0] servo_high = ucmd_pkg::SERVO_HIGH_RST;

	// Bytes waiting to be sent, and commands decoded but not yet seen at the output.
	logic [7:0] rx_backlog [$];
	cmd_reply_t decoded_cmds [$];

	// Bookkeeping. Each variable is written by one process only.
	int         queued_bytes   = 0;
	int         mismatch_count = 0;
	int         idle_cycles    = 0;
	int         send_gap       = 0;
	int         send_calm      = 0;
	int         stall_left     = 0;
	int         recv_calm      = 0;
	int         hold_left      = 0;
	bit         hold_used      = 1'b0;
	logic       pressure_phase = 1'b0;
	cmd_reply_t fresh_reply;
	cmd_reply_t want;

	uart_motor_servo_command_decoder DUT (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Value of a hex digit, or -1 for any other character.
	function automatic int nibble_of(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return int'(c) - int'(CH_ZERO);
		if (c >= CH_UPPER_A && c <= CH_UPPER_F)
			return int'(c) - int'(CH_UPPER_A) + 10;
		if (c >= CH_LOWER_A && c <= CH_LOWER_F)
			return int'(c) - int'(CH_LOWER_A) + 10;
		return -1;
	endfunction

	function automatic bit is_blank_char(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_VTAB || c == CH_FFEED;
	endfunction

	// The duty field: one leading blank is skipped, digits are read until the
	// first non-digit, and the byte is taken as two's complement and clamped.
	function automatic logic signed [7:0] duty_from_hex(input logic [7:0] a, input logic [7:0] b);
		int v;
		int d;
		v = 0;
		if (is_blank_char(a)) begin
			d = nibble_of(b);
			if (d >= 0)
				v = d;
		end else begin
			d = nibble_of(a);
			if (d >= 0) begin
				v = d;
				d = nibble_of(b);
				if (d >= 0)
					v = v * 16 + d;
			end
		end
		if (v > 127)
			v -= 256;
		if (v > 100)
			v = 100;
		if (v < -100)
			v = -100;
		return v[7:0];
	endfunction

	// Feeds one byte into the line model. Returns 1 with the decoded command when
	// the byte ends a line, and 0 otherwise.
	function automatic bit decode_rx_byte(input logic [7:0] c, output cmd_reply_t r);
		bit                is_motor;
		logic signed [7:0] dv;
		longint            mag;
		longint            span;
		longint            p;
		r = '0;
		r.status = ucmd_pkg::ST_INVALID;
		if (c != ucmd_pkg::CHAR_CR && c != ucmd_pkg::CHAR_LF) begin
			// Bytes past the capacity are dropped; only the first four are kept.
			if (line_len < ucmd_pkg::LINE_CAPACITY) begin
				if (line_len < ucmd_pkg::HEAD_DEPTH)
					line_head[line_len] = c;
				line_len++;
			end
			return 1'b0;
		end
		if (line_len >= ucmd_pkg::HEAD_DEPTH &&
				(line_head[0] == ucmd_pkg::CHAR_M || line_head[0] == ucmd_pkg::CHAR_S)) begin
			is_motor = line_head[0] == ucmd_pkg::CHAR_M;
			if (line_head[1] != ucmd_pkg::CHAR_ONE && line_head[1] != ucmd_pkg::CHAR_TWO) begin
				r.status = is_motor ? ucmd_pkg::ST_BAD_MOTOR : ucmd_pkg::ST_BAD_SERVO;
			end else begin
				r.unit = (line_head[1] == ucmd_pkg::CHAR_ONE) ? 2'd1 : 2'd2;
				dv = duty_from_hex(line_head[2], line_head[3]);
				r.duty = dv;
				if (is_motor) begin
					// The magnitude drives one of the two outputs, picked by the sign.
					mag = (dv < 0) ? -longint'(dv) : longint'(dv);
					p = (mag * longint'(motor_full)) / 100;
					r.status = ucmd_pkg::ST_MOTOR_SET;
					if (dv >= 0)
						r.fwd = p[15:0];
					else
						r.rev = p[15:0];
				end else begin
					// The span may be negative when the low pulse exceeds the high one.
					// Division truncates toward zero, as SystemVerilog does for signed values.
					span = longint'(servo_high) - longint'(servo_low);
					p = (longint'(dv) * span) / 100 + longint'(servo_low);
					r.status = ucmd_pkg::ST_SERVO_SET;
					r.neg = p < 0;
					if (r.unit == 2'd1 && dv >= 0 && p >= 0)
						r.servo = (p > 65535) ? 16'hFFFF : p[15:0];
				end
			end
		end
		line_len = 0;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Idle patterns
	// ------------------------------------------------------------------

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// Byte driver
	// ------------------------------------------------------------------

	// At every edge the driver first checks whether the byte on the port was
	// taken. A taken byte goes through the predictor at once, so the command it
	// completes is queued before the block can show it. A stalled byte stays on
	// the port unchanged. Otherwise the driver either sits out its gap or offers
	// the next byte from the backlog. During the pressure phase it sends with no
	// gaps so that the pipeline fills up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (send_calm > 0)
				send_calm--;
			else if ($urandom_range(0, 299) == 0)
				send_calm = $urandom_range(40, 160);
			if (in_valid && !in_stall) begin
				if (decode_rx_byte(rx_byte, fresh_reply))
					decoded_cmds.push_back(fresh_reply);
				send_gap = (send_calm > 0 || pressure_phase) ? 0 : pick_gap();
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (rx_backlog.size() > 0) begin
					rx_byte  <= rx_backlog.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
			mismatch_count++;
		end
	endtask

	// Every result transfer is matched against the oldest decoded command. The
	// monitor also drives out_stall: random stalls with calm stretches, and once,
	// when the pressure phase begins, a long hold that lets the block back up
	// all the way to its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (decoded_cmds.size() == 0) begin
					$error("Result transfer with no command pending: status %0d unit %0d duty %0d",
						status, unit, duty);
					mismatch_count++;
				end else begin
					want = decoded_cmds.pop_front();
					check_field("status", int'(want.status), int'(status));
					check_field("unit", int'(want.unit), int'(unit));
					check_field("duty", int'(want.duty), int'(duty));
					check_field("forward_pulse", int'(want.fwd), int'(forward_pulse));
					check_field("reverse_pulse", int'(want.rev), int'(reverse_pulse));
					check_field("servo_pulse", int'(want.servo), int'(servo_pulse));
					check_field("servo_pulse_negative", int'(want.neg), int'(servo_pulse_negative));
				end
			end
			if (recv_calm > 0)
				recv_calm--;
			else if ($urandom_range(0, 299) == 0)
				recv_calm = $urandom_range(40, 160);
			if (pressure_phase && !hold_used) begin
				hold_left = HOLD_CYCLES;
				hold_used = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = (recv_calm > 0) ? 0 : pick_gap();
				out_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------

	// Counts cycles in which no transfer of any kind happens.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles == WATCHDOG_LIMIT) begin
					$error("No transfer for %0d cycles", WATCHDOG_LIMIT);
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic push_byte(input logic [7:0] b);
		rx_backlog.push_back(b);
		queued_bytes++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_line(input string s, input logic [7:0] term);
		push_text(s);
		push_byte(term);
	endtask

	// Any byte that does not end a line.
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == ucmd_pkg::CHAR_CR || b == ucmd_pkg::CHAR_LF);
		return b;
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_VTAB;
			default: return CH_FFEED;
		endcase
	endfunction

	// A character for the duty field: mostly a hex digit in either case,
	// sometimes a blank, sometimes anything else.
	function automatic logic [7:0] duty_char();
		int pick;
		int nib;
		pick = $urandom_range(0, 99);
		nib  = $urandom_range(0, 15);
		if (pick < 75) begin
			if (nib < 10)
				return 8'(int'(CH_ZERO) + nib);
			if ($urandom_range(0, 1))
				return 8'(int'(CH_UPPER_A) + (nib - 10));
			return 8'(int'(CH_LOWER_A) + (nib - 10));
		end
		if (pick < 85)
			return blank_char();
		return plain_byte();
	endfunction

	// Most lines are well-formed commands with random content and an
	// occasional tail, some of it long enough to run past the capacity. The
	// rest are cut-off commands and plain noise, which may hold line ends of
	// its own.
	task automatic queue_random_line();
		logic [7:0] head [4];
		int         kind;
		int         tail;
		kind    = $urandom_range(0, 99);
		head[0] = $urandom_range(0, 1) ? ucmd_pkg::CHAR_M : ucmd_pkg::CHAR_S;
		head[1] = ($urandom_range(0, 9) != 0)
			? ($urandom_range(0, 1) ? ucmd_pkg::CHAR_ONE : ucmd_pkg::CHAR_TWO)
			: plain_byte();
		head[2] = duty_char();
		head[3] = duty_char();
		if (kind < 72) begin
			for (int i = 0; i < 4; i++)
				push_byte(head[i]);
			tail = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 2);
			repeat (tail)
				push_byte(plain_byte());
		end else if (kind < 86) begin
			tail = $urandom_range(0, 3);
			for (int i = 0; i < tail; i++)
				push_byte(head[i]);
		end else begin
			tail = $urandom_range(0, 8);
			repeat (tail)
				push_byte(8'($urandom_range(0, 255)));
		end
		push_byte($urandom_range(0, 1) ? ucmd_pkg::CHAR_CR : ucmd_pkg::CHAR_LF);
	endtask

	// Waits until every byte is sent and every decoded command has come out.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (rx_backlog.size() != 0 || in_valid || decoded_cmds.size() != 0);
	endtask

	// One register write. The predictor's copy follows once the transfer is done;
	// the block is idle at this point, so no byte can see the change early.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ucmd_pkg::CFG_MOTOR_FULL: motor_full = val;
			ucmd_pkg::CFG_SERVO_LOW:  servo_low  = val;
			ucmd_pkg::CFG_SERVO_HIGH: servo_high = val;
			default: ;
		endcase
	endtask

	// One register setting: the clamp limits of both kinds, then random lines.
	// Ends with the sender paused until every result has come out.
	task automatic run_phase(input logic [15:0] full, input logic [15:0] low, input logic [15:0] high);
		int start;
		write_reg(ucmd_pkg::CFG_MOTOR_FULL, full);
		write_reg(ucmd_pkg::CFG_SERVO_LOW, low);
		write_reg(ucmd_pkg::CFG_SERVO_HIGH, high);
		@(negedge clk);
		start = queued_bytes;
		push_line("M164", ucmd_pkg::CHAR_CR);
		push_line("M29C", ucmd_pkg::CHAR_LF);
		push_line("S164", ucmd_pkg::CHAR_CR);
		push_line("S19C", ucmd_pkg::CHAR_LF);
		push_line("S280", ucmd_pkg::CHAR_CR);
		while (queued_bytes - start < PHASE_BYTES)
			queue_random_line();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed lines under the reset register values.
		push_byte(ucmd_pkg::CHAR_LF);             // empty line
		push_byte(ucmd_pkg::CHAR_CR);             // empty line, other terminator
		push_line("M1", ucmd_pkg::CHAR_CR);       // too short
		push_line("X150", ucmd_pkg::CHAR_LF);     // unknown command letter
		push_line("m150", ucmd_pkg::CHAR_CR);     // letters are case sensitive
		push_line("M350", ucmd_pkg::CHAR_CR);     // bad motor number
		push_line("S050", ucmd_pkg::CHAR_LF);     // bad servo number
		push_line("M17F", ucmd_pkg::CHAR_CR);     // +127 clamps to +100
		push_line("M180", ucmd_pkg::CHAR_LF);     // -128 clamps to -100
		push_line("M19C", ucmd_pkg::CHAR_CR);     // exactly -100
		push_line("M264", ucmd_pkg::CHAR_CR);     // exactly +100
		push_line("M1ff", ucmd_pkg::CHAR_LF);     // lowercase digits, -1
		push_text("M2");                          // a leading blank is skipped
		push_byte(CH_TAB);
		push_line("a", ucmd_pkg::CHAR_CR);
		push_text("M1");                          // blank followed by a non-digit reads as zero
		push_byte(CH_SPACE);
		push_line("-", ucmd_pkg::CHAR_CR);
		push_text("S1");
		push_byte(CH_VTAB);
		push_line("9", ucmd_pkg::CHAR_LF);
		push_text("S2");
		push_byte(CH_FFEED);
		push_line("F", ucmd_pkg::CHAR_CR);
		push_line("M1-5", ucmd_pkg::CHAR_CR);     // signs are not digits
		push_line("M1+5", ucmd_pkg::CHAR_LF);
		push_line("M1A-", ucmd_pkg::CHAR_CR);     // a single digit
		push_line("M1zz", ucmd_pkg::CHAR_LF);     // no digit at all
		push_line("S164", ucmd_pkg::CHAR_CR);
		push_line("S19C", ucmd_pkg::CHAR_LF);     // servo pulse below zero sets the flag
		push_line("S1C0", ucmd_pkg::CHAR_CR);
		push_line("S1E7", ucmd_pkg::CHAR_LF);     // negative duty landing exactly on zero
		push_line("S264", ucmd_pkg::CHAR_CR);     // servo 2 reports no pulse
		push_line("S100", ucmd_pkg::CHAR_CR);
		push_line("S1 5xyz", ucmd_pkg::CHAR_LF);  // bytes after the fourth are ignored
		push_text("M150");                        // a line longer than the capacity
		repeat (70)
			push_byte(plain_byte());
		push_byte(ucmd_pkg::CHAR_CR);
		push_line("S212", ucmd_pkg::CHAR_LF);     // the count starts over after a long line
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		// Register settings, the extremes first. The second one gives a negative
		// servo span, the third a zero span.
		run_phase(16'hFFFF, 16'h0000, 16'hFFFF);
		run_phase(16'h0000, 16'hFFFF, 16'h0000);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF);
		write_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
		run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)));
		run_phase(16'd1, 16'd100, 16'd7);
		run_phase(ucmd_pkg::MOTOR_FULL_RST, ucmd_pkg::SERVO_LOW_RST, ucmd_pkg::SERVO_HIGH_RST);

		// Pressure: the receiver holds off for a long stretch while short
		// commands keep coming back to back, so the block has to stall its input.
		@(posedge clk);
		pressure_phase <= 1'b1;
		@(negedge clk);
		repeat (25) begin
			push_byte($urandom_range(0, 1) ? ucmd_pkg::CHAR_M : ucmd_pkg::CHAR_S);
			push_byte($urandom_range(0, 1) ? ucmd_pkg::CHAR_ONE : ucmd_pkg::CHAR_TWO);
			push_byte(duty_char());
			push_byte(duty_char());
			push_byte(ucmd_pkg::CHAR_CR);
		end
		wait_drained();
		@(posedge clk);
		pressure_phase <= 1'b0;

		// Leave room for any stray result before the verdict.
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* uart_motor_servo_command_decoder.f */
hdl/ucmd_pkg.sv
hdl/ucmd_line.sv
hdl/ucmd_mul.sv
hdl/ucmd_div.sv
hdl/uart_motor_servo_command_decoder.sv
tb/tb.sv
